FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Types and constants of the masked template difference block.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    // wide enough for any size plus border up to the largest frame
    localparam int CALC_W     = 14;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd2;

    typedef struct packed {
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } pix_t;

    typedef struct packed {
        logic [7:0] diff_red;
        logic [7:0] diff_green;
        logic [7:0] diff_blue;
        logic       frame_end;
    } res_t;

    typedef struct packed {
        logic [9:0] frame_width;
        logic [8:0] frame_height;
        logic [7:0] border_width;
    } cfg_t;

    typedef struct packed {
        logic loaded;
        logic border;
        logic frame_end;
    } pos_flags_t;

endpackage

FILE: sv/tad_stream_if.sv
// ----------------------------------------------------------------------------
// tad_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tad_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input ready, input data);

endinterface

FILE: sv/template_abs_diff_border_mask.sv
// ----------------------------------------------------------------------------
// template_abs_diff_border_mask
// Path: an accepted pixel passes the stage-1 registers, then the result register.
// Throughput: one pixel per cycle unless results stall; the RAM gives one access
//   per cycle, a write during the template frame and a registered read afterwards.
// Reset: counters, handshake state and config registers reset; payload registers
//   and template RAM are not cleared; the first frame after reset becomes the template.
// ----------------------------------------------------------------------------
module template_abs_diff_border_mask #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tad_stream_if.sink                         pix,
    tad_stream_if.source                       res,
    input  logic                               cfg_we,
    input  logic [tad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tad_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tad_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    cfg_t              cfg_reg;
    logic              fire, s1_adv;
    logic [ADDR_W-1:0] addr;
    pos_flags_t        flags;
    logic [23:0]       tmpl;
    pix_t              pix_d;

    logic              s1_valid_reg, s1_valid_next;
    pix_t              s1_pix_reg;
    logic              s1_zero_reg;
    logic              s1_end_reg;
    logic              res_valid_reg, res_valid_next;
    res_t              res_data_reg, res_data_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 10'd640;
            cfg_reg.frame_height <= 9'd480;
            cfg_reg.border_width <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[9:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[8:0];
                REG_BORDER_WIDTH: cfg_reg.border_width <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign pix_d     = pix.data;
    assign pix.ready = !s1_valid_reg || !res_valid_reg || res.ready;
    assign fire      = pix.valid && pix.ready;
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res.ready);

    tad_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (fire),
        .cfg   (cfg_reg),
        .addr  (addr),
        .flags (flags)
    );

    // write during the template frame, read afterwards
    tad_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_tmpl_ram (
        .clk   (clk),
        .en    (fire),
        .we    (!flags.loaded),
        .addr  (addr),
        .wdata ({pix_d.pix_red, pix_d.pix_green, pix_d.pix_blue}),
        .rdata (tmpl)
    );

    always_comb
    begin
        if (fire)
            s1_valid_next = flags.loaded;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;

        res_data_next = res_data_reg;
        if (s1_adv)
        begin
            res_data_next.frame_end = s1_end_reg;
            if (s1_zero_reg)
            begin
                res_data_next.diff_red   = 8'd0;
                res_data_next.diff_green = 8'd0;
                res_data_next.diff_blue  = 8'd0;
            end
            else
            begin
                res_data_next.diff_red   = abs_diff(s1_pix_reg.pix_red, tmpl[23:16]);
                res_data_next.diff_green = abs_diff(s1_pix_reg.pix_green, tmpl[15:8]);
                res_data_next.diff_blue  = abs_diff(s1_pix_reg.pix_blue, tmpl[7:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload: hold the accepted pixel until the template word arrives
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_pix_reg  <= pix_d;
            s1_end_reg  <= flags.frame_end;
            s1_zero_reg <= flags.border ||
                           ((pix_d.pix_red == 8'd0) && (pix_d.pix_green == 8'd0) &&
                            (pix_d.pix_blue == 8'd0));
        end
        res_data_reg <= res_data_next;
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

endmodule

FILE: sv/tad_ram.sv
// ----------------------------------------------------------------------------
// tad_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 307200
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tad_pos.sv
// ----------------------------------------------------------------------------
// tad_pos
// Raster position tracker: row/column counters, template address, border
// flag, frame end and the template-loaded flag.
// ----------------------------------------------------------------------------
module tad_pos #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      step,
    input  tad_pkg::cfg_t                             cfg,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   addr,
    output tad_pkg::pos_flags_t                       flags
);

    import tad_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              loaded_reg, loaded_next;

    logic [CALC_W-1:0] w_raw, h_raw, w_eff, h_eff, bw, col_ext, row_ext;
    logic              last_col, last_row;

    // clamp the frame size into 1..MAX
    always_comb
    begin
        w_raw = CALC_W'(cfg.frame_width);
        h_raw = CALC_W'(cfg.frame_height);
        if (w_raw == '0)
            w_eff = CALC_W'(1);
        else if (w_raw > CALC_W'(MAX_WIDTH))
            w_eff = CALC_W'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw == '0)
            h_eff = CALC_W'(1);
        else if (h_raw > CALC_W'(MAX_HEIGHT))
            h_eff = CALC_W'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    assign bw       = CALC_W'(cfg.border_width);
    assign col_ext  = CALC_W'(col_reg);
    assign row_ext  = CALC_W'(row_reg);
    assign last_col = (col_ext + CALC_W'(1)) >= w_eff;
    assign last_row = (row_ext + CALC_W'(1)) >= h_eff;

    // a row beyond a shrunk height falls on the bottom border test
    assign flags.border    = (row_ext < bw) || (h_eff <= row_ext + bw) ||
                             (col_ext < bw) || (w_eff <= col_ext + bw);
    assign flags.frame_end = last_col && last_row;
    assign flags.loaded    = loaded_reg;

    assign addr = ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        loaded_next = loaded_reg;
        if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next    = '0;
                    loaded_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            loaded_reg <= loaded_next;
        end
    end

endmodule

FILE: sv/tad_checker.sv
// ----------------------------------------------------------------------------
// tad_checker
// Port-level checks of the masked template difference block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tad_checker (
    input  logic         clk,
    input  logic         rst_n,
    tad_stream_if.sink   pix,
    tad_stream_if.source res
);

    logic pix_fire;

    assign pix_fire = pix.valid && pix.ready;

    // a stalled result holds its valid and payload
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res.valid && !res.ready, res.valid && $stable(res.data))

    // with the result register empty, the input side never stalls
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !res.valid, pix.ready)

    // a fresh result comes from an item that went through stage 1 without a stall
    `ASSERT_IMPLY(a_res_latency, clk, rst_n, $rose(res.valid), $past(pix_fire, 2))

endmodule

bind template_abs_diff_border_mask tad_checker u_tad_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .pix   (pix),
    .res   (res)
);

FILE: dv/template_abs_diff_border_mask_chk.sv
// ----------------------------------------------------------------------------
// template_abs_diff_border_mask_chk
// Watches the pixel, result and register ports of the masked template
// difference block. Keeps its own template store, counters and frame
// settings, predicts the result of each pixel accepted after the template
// frame and compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module template_abs_diff_border_mask_chk #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tad_stream_if.monitor                  pix,
    tad_stream_if.monitor                  res,
    input  logic                           cfg_we,
    input  logic [tad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tad_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);

    import tad_pkg::*;

    pix_t tmpl_store [MAX_WIDTH*MAX_HEIGHT];
    bit   tmpl_loaded;
    int   row_cnt;
    int   col_cnt;
    cfg_t frame_cfg;
    res_t pending_diffs [$];

    function automatic int eff_size(input int v, input int limit);
        if (v < 1)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic logic [7:0] chan_dist(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Advance the frame position by one pixel; return 1 when a result is due.
    function automatic bit mask_diff(input pix_t px, output res_t diff);
        int   w;
        int   h;
        int   bw;
        int   row;
        int   col;
        int   addr;
        bit   last_col;
        bit   last_row;
        bit   border;
        bit   produced;
        pix_t tp;
        w        = eff_size(int'(frame_cfg.frame_width), MAX_WIDTH);
        h        = eff_size(int'(frame_cfg.frame_height), MAX_HEIGHT);
        bw       = int'(frame_cfg.border_width);
        last_col = (col_cnt + 1 >= w);
        last_row = (row_cnt + 1 >= h);
        row      = (row_cnt >= MAX_HEIGHT) ? MAX_HEIGHT - 1 : row_cnt;
        col      = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
        addr     = row * MAX_WIDTH + col;
        diff     = '0;
        produced = tmpl_loaded;
        if (!tmpl_loaded) begin
            tmpl_store[addr] = px;
        end
        else begin
            // a row or column past the current size lands in the border
            border = (row_cnt < bw) || (h - row_cnt <= bw) ||
                     (col_cnt < bw) || (w - col_cnt <= bw);
            if (!border && px != '0) begin
                tp              = tmpl_store[addr];
                diff.diff_red   = chan_dist(px.pix_red, tp.pix_red);
                diff.diff_green = chan_dist(px.pix_green, tp.pix_green);
                diff.diff_blue  = chan_dist(px.pix_blue, tp.pix_blue);
            end
            diff.frame_end = last_col && last_row;
        end
        if (last_col) begin
            col_cnt = 0;
            if (last_row) begin
                row_cnt     = 0;
                tmpl_loaded = 1'b1;
            end
            else begin
                row_cnt = row_cnt + 1;
            end
        end
        else begin
            col_cnt = col_cnt + 1;
        end
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        res_t got;
        res_t diff;
        if (!rst_n) begin
            tmpl_loaded = 1'b0;
            row_cnt     = 0;
            col_cnt     = 0;
            frame_cfg.frame_width  = 10'd640;
            frame_cfg.frame_height = 9'd480;
            frame_cfg.border_width = 8'd0;
            pending_diffs.delete();
            pending = 0;
        end
        else begin
            if (res.valid && res.ready) begin
                got = res.data;
                if (pending_diffs.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, got %0h", $time, got);
                end
                else begin
                    want = pending_diffs.pop_front();
                    check_field("diff_red", want.diff_red, got.diff_red);
                    check_field("diff_green", want.diff_green, got.diff_green);
                    check_field("diff_blue", want.diff_blue, got.diff_blue);
                    check_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_cfg.frame_width  = cfg_data[9:0];
                    REG_FRAME_HEIGHT: frame_cfg.frame_height = cfg_data[8:0];
                    REG_BORDER_WIDTH: frame_cfg.border_width = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                if (mask_diff(pix.data, diff))
                    pending_diffs.push_back(diff);
            end
            pending = pending_diffs.size();
        end
    end

endmodule

FILE: dv/template_abs_diff_border_mask_tb.sv
// ----------------------------------------------------------------------------
// template_abs_diff_border_mask_tb
// Loads a small template frame, then runs directed frames and random phases
// of frame size and border settings with random pixels, random gaps on both
// ports and one long result stall. Wide and tall phases that run past the
// template carry only zero pixels and return to the frame origin after.
// The checker predicts every result.
// ----------------------------------------------------------------------------
module template_abs_diff_border_mask_tb;

    import tad_pkg::*;

    localparam int MAX_W        = 640;
    localparam int MAX_H        = 480;
    localparam int HALF         = 4;
    localparam int TMPL_COLS    = 8;
    localparam int TMPL_ROWS    = 10;
    localparam int ITEMS_TARGET = 750;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int WIDE_MAX     = (1 << CFG_DATA_W) - 1;
    localparam int TALL_MAX     = 511;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    quiet;
    int                    sent_cnt;
    bit                    tx_steady;
    bit                    squeeze;

    tad_stream_if #(.payload_t(pix_t)) pix_ch ();
    tad_stream_if #(.payload_t(res_t)) res_ch ();

    template_abs_diff_border_mask #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    template_abs_diff_border_mask_chk #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #HALF clk = ~clk;

    function automatic int gap_len(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pix_t rand_pixel();
        logic [31:0] rnd;
        int          r;
        r   = $urandom_range(0, 15);
        rnd = $urandom;
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return rnd[23:0];
    endfunction

    // Write all three registers, with junk in the bits each register drops.
    task automatic set_frame(input int w, input int h, input int b);
        logic [CFG_DATA_W-1:0] hv;
        logic [CFG_DATA_W-1:0] bv;
        hv = CFG_DATA_W'(h);
        bv = CFG_DATA_W'(b);
        hv[9]   = 1'($urandom_range(0, 1));
        bv[9:8] = 2'($urandom_range(0, 3));
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= hv;
        @(posedge clk);
        cfg_index <= REG_BORDER_WIDTH;
        cfg_data  <= bv;
        @(posedge clk);
        if ($urandom_range(0, 3) == 0) begin
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input pix_t px);
        int idle;
        idle = gap_len(tx_steady);
        sent_cnt = sent_cnt + 1;
        if (idle > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= px;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    // Hold until every result is in and the pipeline has emptied.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic play(input int n, input bit patterned);
        int   i;
        pix_t px;
        for (i = 0; i < n; i++) begin
            px = rand_pixel();
            if (patterned) begin
                case (i % 5)
                    0: px = '1;
                    1: px = '0;
                    2: px = {8'h00, 8'hFF, 8'h80};
                    3: px = {8'hFF, 8'h00, 8'h01};
                    default: ;
                endcase
            end
            send_pixel(px);
        end
        drain();
    endtask

    // Zero pixels never look at the template, so any position is safe.
    task automatic play_blank(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_pixel('0);
        drain();
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin : receiver
        int stall;
        bit squeezed;
        bit rx_steady;
        squeezed     = 1'b0;
        rx_steady    = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            if (squeeze && !squeezed) begin
                squeezed = 1'b1;
                stall    = HOLD_CYCLES;
            end
            else begin
                stall = gap_len(rx_steady);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet);
            $display("** template_abs_diff_border_mask: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        int w;
        int h;
        int b;
        int n;
        int r;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data  = '0;
        tx_steady    = 1'b0;
        squeeze      = 1'b0;
        sent_cnt     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Template: a small frame at the origin.
        set_frame(TMPL_COLS, TMPL_ROWS, 0);
        play(TMPL_COLS * TMPL_ROWS, 1'b0);

        // Border ring with saturated, zero and mixed pixels inside.
        set_frame(5, 4, 1);
        play(20, 1'b1);
        // Zero size acts as one pixel; a border past the frame masks all.
        set_frame(0, 0, 255);
        play(2, 1'b1);
        // Shrink the frame while the column counter is past the new width.
        set_frame(4, 3, 0);
        play(3, 1'b0);
        set_frame(2, 2, 0);
        play(3, 1'b0);

        // Stall the result port while the pixel side keeps pushing.
        tx_steady = 1'b1;
        squeeze   = 1'b1;
        set_frame(TMPL_COLS, TMPL_ROWS, 1);
        play(80, 1'b0);

        while (sent_cnt < ITEMS_TARGET) begin
            kind      = $urandom_range(0, 11);
            tx_steady = ($urandom_range(0, 4) == 0);
            r         = $urandom_range(0, 9);
            if (r < 6)
                b = $urandom_range(0, 3);
            else if (r == 6)
                b = 240;
            else if (r == 7)
                b = 255;
            else
                b = $urandom_range(0, 255);
            if (kind == 11) begin
                // Return to the frame origin before a single wide row.
                set_frame(1, 1, b);
                play_blank(1);
                r = $urandom_range(0, 2);
                if (r == 0)
                    w = MAX_W;
                else if (r == 1)
                    w = WIDE_MAX;
                else
                    w = $urandom_range(TMPL_COLS + 1, WIDE_MAX);
                h = $urandom_range(0, 1);
                if (w >= MAX_W && sent_cnt <= ITEMS_TARGET / 2 && $urandom_range(0, 2) == 0)
                    n = MAX_W;
                else
                    n = $urandom_range(1, 60);
            end
            else if (kind == 10) begin
                w = ($urandom_range(0, 1) == 1) ? 1 : $urandom_range(0, TMPL_COLS);
                r = $urandom_range(0, 2);
                h = (r == 0) ? MAX_H : (r == 1) ? TALL_MAX : $urandom_range(11, TALL_MAX);
                if (w == 1 && h >= MAX_H && sent_cnt <= ITEMS_TARGET / 2 &&
                    $urandom_range(0, 1) == 1)
                    n = MAX_H;
                else
                    n = $urandom_range(1, 40);
            end
            else begin
                w = $urandom_range(0, TMPL_COLS);
                h = $urandom_range(0, TMPL_ROWS);
                if (w > 0 && h > 0 && $urandom_range(0, 1) == 1)
                    n = w * h * $urandom_range(1, 3);
                else
                    n = $urandom_range(1, 30);
            end
            set_frame(w, h, b);
            if (kind >= 10) begin
                // Run past the template with zero pixels, then back to the origin.
                play_blank(n);
                set_frame(1, 1, b);
                play_blank(1);
            end
            else begin
                play(n, 1'b0);
            end
        end

        repeat (TAIL) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** template_abs_diff_border_mask: PASSED **");
        else
            $display("** template_abs_diff_border_mask: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tad_pkg.sv
sv/tad_stream_if.sv
sv/tad_ram.sv
sv/tad_pos.sv
sv/template_abs_diff_border_mask.sv
sv/tad_checker.sv
dv/template_abs_diff_border_mask_chk.sv
dv/template_abs_diff_border_mask_tb.sv
